// File: sv/esu_pkg.sv
// ============================================================================
// esu_pkg
// Shared types and constants for the string unescape / UTF-8 encode block.
// ============================================================================
`default_nettype none

package esu_pkg;

    // Decoder phase codes
    localparam logic [2:0] PH_START = 3'd0;  // awaiting first byte
    localparam logic [2:0] PH_TEXT  = 3'd1;  // plain content
    localparam logic [2:0] PH_ESC   = 3'd2;  // byte after backslash
    localparam logic [2:0] PH_HEX1  = 3'd3;  // hex digits of first unit
    localparam logic [2:0] PH_HI    = 3'd4;  // high surrogate seen, want backslash
    localparam logic [2:0] PH_HI_BS = 3'd5;  // want 'u' of low surrogate
    localparam logic [2:0] PH_HEX2  = 3'd6;  // hex digits of low surrogate

    // Register indexes on the config port
    localparam logic CFG_QUOTE_CHAR  = 1'b0;
    localparam logic CFG_QUOTED_MODE = 1'b1;

    localparam logic [7:0]  QUOTE_RESET = 8'd34;
    localparam logic [15:0] LEN_MAX     = 16'hFFFF;

    // Surrogate ranges
    localparam logic [15:0] HI_SUR_LO = 16'hD800;
    localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
    localparam logic [15:0] LO_SUR_LO = 16'hDC00;
    localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // UTF-8 lead and continuation marks
    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [7:0] UTF_MASK  = 8'h3F;

    // Per-string decoder state
    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] hex_value;
        logic [1:0]  hex_digits;
        logic [9:0]  hi_bits;
        logic [15:0] length;
        logic        failure;
        logic        closed;
    } st_t;

    localparam st_t ST_RESET = '{
        phase:      PH_START,
        hex_value:  16'd0,
        hex_digits: 2'd0,
        hi_bits:    10'd0,
        length:     16'd0,
        failure:    1'b0,
        closed:     1'b0
    };

    // Group of results caused by one input byte
    typedef struct packed {
        logic [3:0][7:0] bytes;    // decoded bytes, first in [0]
        logic [2:0]      nbytes;   // decoded bytes in this group
        logic [2:0]      count;    // result items in this group
        logic            last;     // group closes the string
        logic            failed;   // final status
        logic [15:0]     length;   // final decoded length
    } grp_t;

endpackage

`default_nettype wire

// File: sv/esu_decode.sv
// ============================================================================
// esu_decode
// One-byte step of the unescaper: next state and the group of results.
// ============================================================================
`default_nettype none

module esu_decode (
    input  wire esu_pkg::st_t  st,
    input  wire logic [7:0]    in_byte,
    input  wire logic          last_byte,
    input  wire logic [7:0]    quote_val,
    input  wire logic          quoted_mode,
    output esu_pkg::st_t       st_next,
    output esu_pkg::grp_t      grp
);

    // hex digit value; bit 4 flags a valid digit
    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9")
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= "a" && c <= "f")
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= "A" && c <= "F")
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    logic        q;
    logic        is_quote;
    logic        active;
    logic [4:0]  nib;
    logic [15:0] hex_new;
    logic        hex_full;
    logic [20:0] cp;
    logic        do_enc;
    logic        put1;
    logic [7:0]  put1_val;
    logic [3:0][7:0] bytes;
    logic [2:0]  nbytes;
    logic [16:0] len_sum;
    esu_pkg::st_t s;

    assign q        = quoted_mode;
    assign is_quote = q && (in_byte == quote_val);
    assign active   = !st.failure && !st.closed;
    assign nib      = hex_nib(in_byte);
    assign hex_new  = {st.hex_value[11:0], nib[3:0]};
    assign hex_full = (st.hex_digits == 2'd3);

    // State step
    always_comb
    begin
        s        = st;
        cp       = 21'd0;
        do_enc   = 1'b0;
        put1     = 1'b0;
        put1_val = 8'd0;
        if (active)
        begin
            case (st.phase)
                esu_pkg::PH_START, esu_pkg::PH_TEXT:
                begin
                    if (st.phase == esu_pkg::PH_START && q)
                    begin
                        if (is_quote)
                            s.phase = esu_pkg::PH_TEXT;
                        else
                            s.failure = 1'b1;
                    end
                    else
                    begin
                        s.phase = esu_pkg::PH_TEXT;
                        if (is_quote)
                            s.closed = 1'b1;
                        else if (in_byte == "\\")
                            s.phase = esu_pkg::PH_ESC;
                        else
                        begin
                            put1     = 1'b1;
                            put1_val = in_byte;
                        end
                    end
                end
                esu_pkg::PH_ESC:
                begin
                    s.phase = esu_pkg::PH_TEXT;
                    put1    = 1'b1;
                    case (in_byte)
                        "\\":    put1_val = 8'h5C;
                        "/":     put1_val = 8'h2F;
                        "b":     put1_val = 8'd8;
                        "f":     put1_val = 8'd12;
                        "n":     put1_val = 8'd10;
                        "r":     put1_val = 8'd13;
                        "t":     put1_val = 8'd9;
                        "u":
                        begin
                            put1         = 1'b0;
                            s.phase      = esu_pkg::PH_HEX1;
                            s.hex_value  = 16'd0;
                            s.hex_digits = 2'd0;
                        end
                        default:
                        begin
                            // unknown escape: quote char when quoted, else error
                            if (q)
                                put1_val = quote_val;
                            else
                            begin
                                put1      = 1'b0;
                                s.failure = 1'b1;
                            end
                        end
                    endcase
                end
                esu_pkg::PH_HEX1, esu_pkg::PH_HEX2:
                begin
                    if (is_quote)
                    begin
                        s.closed  = 1'b1;
                        s.failure = 1'b1;
                    end
                    else if (!nib[4])
                        s.failure = 1'b1;
                    else
                    begin
                        s.hex_value  = hex_new;
                        s.hex_digits = hex_full ? 2'd0 : st.hex_digits + 2'd1;
                        if (hex_full)
                        begin
                            if (st.phase == esu_pkg::PH_HEX1)
                            begin
                                if (hex_new >= esu_pkg::HI_SUR_LO &&
                                    hex_new <= esu_pkg::HI_SUR_HI)
                                begin
                                    s.hi_bits = hex_new[9:0];
                                    s.phase   = esu_pkg::PH_HI;
                                end
                                else if (hex_new >= esu_pkg::LO_SUR_LO &&
                                         hex_new <= esu_pkg::LO_SUR_HI)
                                    s.failure = 1'b1;
                                else
                                begin
                                    cp      = {5'd0, hex_new};
                                    do_enc  = 1'b1;
                                    s.phase = esu_pkg::PH_TEXT;
                                end
                            end
                            else
                            begin
                                if (hex_new >= esu_pkg::LO_SUR_LO &&
                                    hex_new <= esu_pkg::LO_SUR_HI)
                                begin
                                    cp      = esu_pkg::SUPP_BASE +
                                              {1'b0, st.hi_bits, hex_new[9:0]};
                                    do_enc  = 1'b1;
                                    s.phase = esu_pkg::PH_TEXT;
                                end
                                else
                                    s.failure = 1'b1;
                            end
                        end
                    end
                end
                esu_pkg::PH_HI:
                begin
                    if (is_quote)
                    begin
                        s.closed  = 1'b1;
                        s.failure = 1'b1;
                    end
                    else if (in_byte == "\\")
                        s.phase = esu_pkg::PH_HI_BS;
                    else
                        s.failure = 1'b1;
                end
                esu_pkg::PH_HI_BS:
                begin
                    if (in_byte == "u")
                    begin
                        s.phase      = esu_pkg::PH_HEX2;
                        s.hex_value  = 16'd0;
                        s.hex_digits = 2'd0;
                    end
                    else
                        s.failure = 1'b1;
                end
                default:
                    s.failure = 1'b1;
            endcase
        end

        // end-of-string status check
        if (last_byte && !s.failure)
        begin
            if (q)
            begin
                if (!s.closed)
                    s.failure = 1'b1;
            end
            else if (s.phase != esu_pkg::PH_TEXT)
                s.failure = 1'b1;
        end
    end

    // UTF-8 packing of the emitted bytes
    always_comb
    begin
        bytes  = '0;
        nbytes = 3'd0;
        if (put1)
        begin
            bytes[0] = put1_val;
            nbytes   = 3'd1;
        end
        else if (do_enc)
        begin
            if (cp <= 21'h7F)
            begin
                bytes[0] = cp[7:0];
                nbytes   = 3'd1;
            end
            else if (cp <= 21'h7FF)
            begin
                bytes[0] = esu_pkg::UTF_LEAD2 | {3'd0, cp[10:6]};
                bytes[1] = esu_pkg::UTF_CONT | (cp[7:0] & esu_pkg::UTF_MASK);
                nbytes   = 3'd2;
            end
            else if (cp <= 21'hFFFF)
            begin
                bytes[0] = esu_pkg::UTF_LEAD3 | {4'd0, cp[15:12]};
                bytes[1] = esu_pkg::UTF_CONT | ({2'd0, cp[11:6]} & esu_pkg::UTF_MASK);
                bytes[2] = esu_pkg::UTF_CONT | (cp[7:0] & esu_pkg::UTF_MASK);
                nbytes   = 3'd3;
            end
            else
            begin
                bytes[0] = esu_pkg::UTF_LEAD4 | {5'd0, cp[20:18]};
                bytes[1] = esu_pkg::UTF_CONT | ({2'd0, cp[17:12]} & esu_pkg::UTF_MASK);
                bytes[2] = esu_pkg::UTF_CONT | ({2'd0, cp[11:6]} & esu_pkg::UTF_MASK);
                bytes[3] = esu_pkg::UTF_CONT | (cp[7:0] & esu_pkg::UTF_MASK);
                nbytes   = 3'd4;
            end
        end
    end

    // saturating length
    assign len_sum = {1'b0, st.length} + {14'd0, nbytes};

    always_comb
    begin
        st_next        = s;
        st_next.length = len_sum[16] ? esu_pkg::LEN_MAX : len_sum[15:0];
        if (last_byte)
            st_next = esu_pkg::ST_RESET;
    end

    // result group
    always_comb
    begin
        grp.bytes  = bytes;
        grp.nbytes = nbytes;
        grp.count  = (last_byte && nbytes == 3'd0) ? 3'd1 : nbytes;
        grp.last   = last_byte;
        grp.failed = s.failure;
        grp.length = len_sum[16] ? esu_pkg::LEN_MAX : len_sum[15:0];
    end

endmodule

`default_nettype wire

// File: sv/escaped_string_unquote_utf8.sv
// ============================================================================
// escaped_string_unquote_utf8
// Escaped string literal decoder with UTF-8 output, one byte per cycle unless the output holds the input.
// ============================================================================
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   tdata: in_byte; tlast: last_byte
// m_*       out  m_tvalid/m_tready   tdata: out_byte, run_end, failed, length;
//                                    tuser: has_byte; tlast: string_done
// cfg_*     in   cfg_we              cfg_index selects register, cfg_data
//
// An input byte is decoded in the cycle it is accepted; its results sit in
// a group register and are offered from the next cycle, leaving one per cycle while m_tready is high.
// Bytes that decode to 0 or 1 result flow at one per cycle while m_tready is high;
// a byte that makes an n-byte UTF-8 sequence holds the input until its last result is taken at the output port.
// s_tready stays high while the last result of the group is being taken.
// Reset returns the registers to quote 34 / quoted mode and clears the state.
// ============================================================================
`default_nettype none

module escaped_string_unquote_utf8 (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] in_byte
    input  wire logic        s_tlast,    // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [7:0] out_byte, [8] run_end, [9] failed,
                                         // [25:10] decoded_length, [31:26] zero
    output logic             m_tuser,    // [0] has_byte
    output logic             m_tlast,    // string_done
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [7:0]    quote_reg;
    logic          quoted_reg;
    esu_pkg::st_t  st_reg;
    esu_pkg::st_t  st_next;
    esu_pkg::grp_t grp_reg;
    esu_pkg::grp_t grp_next;
    logic          grp_valid_reg;
    logic [1:0]    idx_reg;
    logic          in_fire;
    logic          out_fire;
    logic          item_last;
    logic          has_byte;
    logic          fin;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg  <= esu_pkg::QUOTE_RESET;
            quoted_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                esu_pkg::CFG_QUOTE_CHAR:  quote_reg  <= cfg_data;
                esu_pkg::CFG_QUOTED_MODE: quoted_reg <= cfg_data[0];
                default:                  quote_reg  <= quote_reg;
            endcase
        end
    end

    esu_decode u_decode (
        .st          (st_reg),
        .in_byte     (s_tdata),
        .last_byte   (s_tlast),
        .quote_val   (quote_reg),
        .quoted_mode (quoted_reg),
        .st_next     (st_next),
        .grp         (grp_next)
    );

    // Handshake
    assign item_last = ({1'b0, idx_reg} == grp_reg.count - 3'd1);
    assign out_fire  = m_tvalid && m_tready;
    assign s_tready  = !grp_valid_reg || (m_tready && item_last);
    assign in_fire   = s_tvalid && s_tready;

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= esu_pkg::ST_RESET;
        else if (in_fire)
            st_reg <= st_next;
    end

    // Result group control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (in_fire && grp_next.count != 3'd0)
        begin
            grp_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end
        else if (out_fire)
        begin
            if (item_last)
                grp_valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    // Result group payload
    always_ff @(posedge clk)
    begin
        if (in_fire && grp_next.count != 3'd0)
            grp_reg <= grp_next;
    end

    // Output item select
    assign has_byte = ({1'b0, idx_reg} < grp_reg.nbytes);
    assign fin      = grp_reg.last && item_last;
    assign m_tvalid = grp_valid_reg;
    assign m_tuser  = has_byte;
    assign m_tlast  = fin;
    assign m_tdata  = {6'd0,
                       fin ? grp_reg.length : 16'd0,
                       fin && grp_reg.failed,
                       item_last,
                       has_byte ? grp_reg.bytes[idx_reg] : 8'd0};

    // Checks
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |=>
            (st_reg.phase == esu_pkg::PH_START && st_reg.length == 16'd0 &&
             !st_reg.failure && !st_reg.closed))
        else $error("state not cleared after last byte");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !grp_valid_reg |-> s_tready)
        else $error("input stalled with empty result group");

    a_group_size: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> (grp_reg.count != 3'd0 && grp_reg.count <= 3'd4 &&
                           {1'b0, idx_reg} < grp_reg.count))
        else $error("result index outside group");

    a_last_group: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |=> m_tvalid)
        else $error("last byte produced no result");

endmodule

`default_nettype wire
